@@ design/lage_pkg.sv @@
// Shared types and constants of the life automaton generation engine.
// Holds the operation codes, the sequencer states, the register map and the B3/S23 counts.
// Depends on nothing; the row unit, the register file and the top level import it.
package lage_pkg;

	// Operation carried in the input tuser
	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_READ    = 2'd2
	} lage_kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_ADV_LOAD,
		ST_ADV_ROW,
		ST_ADV_READ,
		ST_RESP
	} lage_state_t;

	// Register map, selected by paddr[2]
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [6:0] COLUMNS_RESET = 7'd64;
	localparam logic [6:0] ROWS_RESET    = 7'd64;

	// Neighbor counts of rule B3/S23
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// Raw register contents handed to the sequencer
	typedef struct packed {
		logic [6:0] columns;
		logic [6:0] rows;
	} lage_cfg_t;

endpackage

@@ design/lage_grid_mem.sv @@
// Cell grid storage: one row of cells per word, one write and one read port.
// Read data is registered. Depends on nothing.
module lage_grid_mem #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Store a row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Fetch a row
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/lage_row_unit.sv @@
// Row update unit: computes the next generation of one row from the rows around it.
// Inputs arrive already masked to the columns in use. Depends on lage_pkg.
module lage_row_unit #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] above,
	input  logic [WIDTH-1:0] center,
	input  logic [WIDTH-1:0] below,
	input  logic [WIDTH-1:0] col_mask,
	output logic [WIDTH-1:0] next_row
);
	import lage_pkg::*;

	logic [WIDTH-1:0] above_l, above_r, center_l, center_r, below_l, below_r;

	function automatic logic [3:0] count8(input logic [7:0] bits);
		logic [3:0] sum;
		sum = '0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + 4'(bits[i]);
		end
		return sum;
	endfunction

	// Align the left and right neighbors of each cell; edges shift in dead cells
	assign above_l  = above << 1;
	assign above_r  = above >> 1;
	assign center_l = center << 1;
	assign center_r = center >> 1;
	assign below_l  = below << 1;
	assign below_r  = below >> 1;

	// Apply birth on three, survival on two or three
	always_comb begin
		logic [3:0] n;
		n = '0;
		for (int c = 0; c < WIDTH; c++) begin
			n = count8({above_l[c], above[c], above_r[c], center_l[c], center_r[c],
				below_l[c], below[c], below_r[c]});
			next_row[c] = col_mask[c] & ((n == BIRTH_COUNT) |
				(center[c] & (n == SURVIVE_COUNT)));
		end
	end

endmodule

@@ design/lage_cfg_regs.sv @@
// APB register file holding the grid size registers.
// Depends on lage_pkg for the register map and reset values.
module lage_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output lage_pkg::lage_cfg_t cfg
);
	import lage_pkg::*;

	logic [6:0] columns_q;
	logic [6:0] rows_q;
	logic       wr_fire;

	assign pready  = 1'b1;
	assign wr_fire = psel & penable & pwrite & pready;

	// Capture register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (wr_fire) begin
			if (paddr[2] == REG_COLUMNS) begin
				columns_q <= pwdata[6:0];
			end else begin
				rows_q <= pwdata[6:0];
			end
		end
	end

	// Return the selected register
	assign prdata = (paddr[2] == REG_ROWS) ? {25'd0, rows_q} : {25'd0, columns_q};

	assign cfg.columns = columns_q;
	assign cfg.rows    = rows_q;

endmodule

@@ design/life_automaton_generation_engine.sv @@
// Top level of the life automaton generation engine: sequencer, grid memory, row update unit.
// Depends on lage_pkg, lage_grid_mem, lage_row_unit and lage_cfg_regs.
//
// Holds a grid of up to MAX_ROWS rows by MAX_COLUMNS columns and advances it by the B3/S23
// rule. Each input transfer writes a cell, advances one generation or reads a cell, and
// yields one result transfer with the addressed cell's state and an out-of-grid flag. The
// grid lives in a memory of one row per word; a single row update unit computes a whole
// new row from three old rows, one row per cycle, while the sequencer streams rows through
// it and writes each new row back in place. A write or read goes from accept through
// ST_FETCH to ST_RESP; an advance goes through ST_ADV_LOAD, a sweep of ST_ADV_ROW over
// every row of the memory, ST_ADV_READ, ST_FETCH and ST_RESP. After reset the block
// clears every row and accepts no input meanwhile; configuration writes are taken
// throughout. The next input is accepted while a result still waits to be taken.
module life_automaton_generation_engine #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] cell_column, [11:6] cell_row, [12] cell_value
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] cell_alive, [1] out_of_grid
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lage_pkg::*;

	localparam int CW  = $clog2(MAX_COLUMNS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int RCW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;

	lage_cfg_t          cfg;
	logic [6:0]         used_cols;
	logic [RCW-1:0]     used_rows;
	logic [MAX_COLUMNS-1:0] col_mask;

	lage_state_t        state_q, state_d;
	logic [1:0]         kind_q;
	logic [5:0]         col_q, row_q;
	logic               val_q, inside_q;
	logic [MAX_COLUMNS-1:0] prev_q, cur_q;
	logic [RW-1:0]      r_q;
	logic               res_alive_q;
	logic               out_valid_q, out_alive_q, out_oog_q;

	logic               mem_wr_en, mem_rd_en;
	logic [RW-1:0]      mem_wr_addr, mem_rd_addr;
	logic [MAX_COLUMNS-1:0] mem_wr_data, mem_rd_data;
	logic [MAX_COLUMNS-1:0] nxt_word, unit_row, rmw_word;

	logic [5:0]         in_col, in_row;
	logic               in_val, in_inside, accept, out_load;
	logic               last_row, row_live, nxt_live, fetch_bit;

	lage_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lage_grid_mem #(
		.WIDTH (MAX_COLUMNS),
		.DEPTH (MAX_ROWS)
	) u_mem (
		.clk       (clk),
		.wr_en     (mem_wr_en),
		.wr_addr   (mem_wr_addr),
		.wr_data   (mem_wr_data),
		.rd_en     (mem_rd_en),
		.rd_addr   (mem_rd_addr),
		.rd_data_q (mem_rd_data)
	);

	lage_row_unit #(
		.WIDTH (MAX_COLUMNS)
	) u_row (
		.above    (prev_q),
		.center   (cur_q),
		.below    (nxt_word),
		.col_mask (col_mask),
		.next_row (unit_row)
	);

	// Clamp the grid size to the storage, at least one, and build the column mask
	always_comb begin
		if (cfg.columns == 7'd0) begin
			used_cols = 7'd1;
		end else if (cfg.columns > 7'(MAX_COLUMNS)) begin
			used_cols = 7'(MAX_COLUMNS);
		end else begin
			used_cols = cfg.columns;
		end
		if (cfg.rows == 7'd0) begin
			used_rows = RCW'(1);
		end else if (RCW'(cfg.rows) > RCW'(MAX_ROWS)) begin
			used_rows = RCW'(MAX_ROWS);
		end else begin
			used_rows = RCW'(cfg.rows);
		end
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			col_mask[c] = (7'(c) < used_cols);
		end
	end

	// Unpack the input transfer
	assign in_col    = s_tdata[5:0];
	assign in_row    = s_tdata[11:6];
	assign in_val    = s_tdata[12];
	assign in_inside = ({1'b0, in_col} < used_cols) && (RCW'(in_row) < used_rows);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || m_tready);

	// Sweep bookkeeping
	assign last_row  = (r_q == RW'(MAX_ROWS - 1));
	assign row_live  = RCW'(r_q) < used_rows;
	assign nxt_live  = (RCW'(r_q) + RCW'(1)) < used_rows;
	assign nxt_word  = nxt_live ? (mem_rd_data & col_mask) : '0;
	assign fetch_bit = mem_rd_data[CW'(col_q)];

	always_comb begin
		rmw_word = mem_rd_data;
		rmw_word[CW'(col_q)] = val_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (last_row) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == KIND_ADVANCE) ? ST_ADV_LOAD : ST_FETCH;
				end
			end
			ST_FETCH:    state_d = ST_RESP;
			ST_ADV_LOAD: state_d = ST_ADV_ROW;
			ST_ADV_ROW: begin
				if (last_row) state_d = ST_ADV_READ;
			end
			ST_ADV_READ: state_d = ST_FETCH;
			ST_RESP: begin
				if (out_load) state_d = ST_IDLE;
			end
			default:     state_d = ST_CLEAR;
		endcase
	end

	// Memory controls per state
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = r_q;
		mem_wr_data = '0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = RW'(in_row);
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			ST_IDLE: begin
				mem_rd_en   = accept;
				mem_rd_addr = (s_tuser == KIND_ADVANCE) ? '0 : RW'(in_row);
			end
			ST_FETCH: begin
				mem_wr_en   = (kind_q == KIND_WRITE) && inside_q;
				mem_wr_addr = RW'(row_q);
				mem_wr_data = rmw_word;
			end
			ST_ADV_LOAD: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = RW'(1);
			end
			ST_ADV_ROW: begin
				mem_wr_en   = 1'b1;
				mem_wr_data = row_live ? unit_row : '0;
				mem_rd_en   = 1'b1;
				mem_rd_addr = r_q + RW'(2);
			end
			ST_ADV_READ: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = RW'(row_q);
			end
			default: begin
				mem_wr_en = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_ADV_ROW) begin
				r_q <= r_q + RW'(1);
			end else if (state_q == ST_ADV_LOAD) begin
				r_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			col_q    <= in_col;
			row_q    <= in_row;
			val_q    <= in_val;
			inside_q <= in_inside;
		end
		if (state_q == ST_ADV_LOAD) begin
			prev_q <= '0;
			cur_q  <= mem_rd_data & col_mask;
		end else if (state_q == ST_ADV_ROW) begin
			prev_q <= cur_q;
			cur_q  <= nxt_word;
		end
		if (state_q == ST_FETCH) begin
			res_alive_q <= inside_q & ((kind_q == KIND_WRITE) ? val_q : fetch_bit);
		end
		if (out_load) begin
			out_alive_q <= res_alive_q;
			out_oog_q   <= ~inside_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_oog_q, out_alive_q};

endmodule
